### hdl/mctg_pkg.sv
// ----------------------------------------------------------------------------
// Multi-core thermal governor package
// Shared constants, codes, queue entry type and the state-to-ratio table.
// ----------------------------------------------------------------------------
package mctg_pkg;

	localparam int CORES      = 16;
	localparam int CORE_W     = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int CORE_IDX_W = 4;
	localparam int TEMP_W     = 18;
	localparam int DUTY_W     = 7;
	localparam int REQ_W      = 8;
	localparam int CNT_W      = 16;
	localparam int POLL_W     = 32;
	localparam int RATIO_W    = 6;
	localparam int PST_W      = 2;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] ACT_SAMPLE     = 2'd0;
	localparam logic [1:0] ACT_SET_PSTATE = 2'd1;
	localparam logic [1:0] ACT_FAN        = 2'd2;

	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_PASSIVE  = 2'd1;
	localparam logic [1:0] REG_CRITICAL = 2'd2;

	localparam logic [TEMP_W-1:0] TEMP_HYST      = 18'd10000;
	localparam logic [TEMP_W-1:0] TEMP_FAN_LOW   = 18'd50000;
	localparam logic [TEMP_W-1:0] TEMP_FAN_MID   = 18'd70000;
	localparam logic [TEMP_W-1:0] PASSIVE_RESET  = 18'd78000;
	localparam logic [TEMP_W-1:0] CRITICAL_RESET = 18'd95000;

	localparam logic [DUTY_W-1:0] DUTY_MIN     = 7'd20;
	localparam logic [DUTY_W-1:0] DUTY_MAX     = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_PASSIVE = 7'd75;
	localparam logic [DUTY_W-1:0] DUTY_LOW     = 7'd30;
	localparam logic [DUTY_W-1:0] DUTY_MID     = 7'd50;
	localparam logic [DUTY_W-1:0] DUTY_RESET   = 7'd35;

	localparam logic [PST_W-1:0] PSTATE_TURBO    = 2'd0;
	localparam logic [PST_W-1:0] PSTATE_BASE     = 2'd1;
	localparam logic [PST_W-1:0] PSTATE_ECO      = 2'd2;
	localparam logic [PST_W-1:0] PSTATE_THROTTLE = 2'd3;

	localparam logic [RATIO_W-1:0] RATIO_TURBO    = 6'd57;
	localparam logic [RATIO_W-1:0] RATIO_BASE     = 6'd42;
	localparam logic [RATIO_W-1:0] RATIO_ECO      = 6'd28;
	localparam logic [RATIO_W-1:0] RATIO_THROTTLE = 6'd14;

	typedef enum logic [1:0] {OP_SAMPLE, OP_SET_PSTATE, OP_FAN, OP_NONE} op_kind_t;
	typedef enum logic [1:0] {TC_NONE, TC_COOL, TC_PASSIVE, TC_CRITICAL} temp_class_t;
	typedef enum logic [1:0] {FR_NONE, FR_PASSIVE, FR_CRITICAL} fan_req_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [CORE_IDX_W-1:0]   core;
		logic                    core_ok;
		logic [TEMP_W-1:0]       temp;
		temp_class_t             tclass;
		logic [PST_W-1:0]        pstate;
		logic [DUTY_W-1:0]       duty;
		logic                    last;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [RATIO_W-1:0] ratio_of(input logic [PST_W-1:0] st);
		logic [RATIO_W-1:0] r;
		case (st)
			PSTATE_TURBO: r = RATIO_TURBO;
			PSTATE_BASE:  r = RATIO_BASE;
			PSTATE_ECO:   r = RATIO_ECO;
			default:      r = RATIO_THROTTLE;
		endcase
		return r;
	endfunction

endpackage

### hdl/mctg_if.sv
// ----------------------------------------------------------------------------
// Multi-core thermal governor channel interfaces
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface mctg_in_if;
	import mctg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [CORE_IDX_W-1:0] core_index;
	logic [TEMP_W-1:0]     temp_mc;
	logic [PST_W-1:0]      pstate_value;
	logic [REQ_W-1:0]      fan_request;
	logic                  poll_last;

	modport source (
		output valid, action, core_index, temp_mc, pstate_value, fan_request, poll_last,
		input  ready
	);
	modport sink (
		input  valid, action, core_index, temp_mc, pstate_value, fan_request, poll_last,
		output ready
	);
endinterface

interface mctg_out_if;
	import mctg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CORE_IDX_W-1:0] out_core;
	logic [PST_W-1:0]      core_pstate;
	logic [RATIO_W-1:0]    perf_ratio;
	logic                  core_throttling;
	logic                  critical_hit;
	logic [CNT_W-1:0]      critical_count;
	logic [DUTY_W-1:0]     fan_duty;
	logic [TEMP_W-1:0]     max_temp_out;
	logic [POLL_W-1:0]     poll_total;
	logic                  poll_done;

	modport source (
		output valid, out_core, core_pstate, perf_ratio, core_throttling, critical_hit,
		       critical_count, fan_duty, max_temp_out, poll_total, poll_done,
		input  ready
	);
	modport sink (
		input  valid, out_core, core_pstate, perf_ratio, core_throttling, critical_hit,
		       critical_count, fan_duty, max_temp_out, poll_total, poll_done,
		output ready
	);
endinterface

### hdl/mctg_front.sv
// ----------------------------------------------------------------------------
// Multi-core thermal governor front end
// Accepts input transfers, classifies the temperature against the limits,
// clamps fan requests and writes one operation into the queue.
// ----------------------------------------------------------------------------
module mctg_front (
	mctg_in_if.sink                     item,
	input  logic                        gov_enable,
	input  logic [mctg_pkg::TEMP_W-1:0] passive_limit,
	input  logic [mctg_pkg::TEMP_W-1:0] critical_limit,
	input  mctg_pkg::q_stat_t           q_stat,
	output logic                        push,
	output mctg_pkg::op_t               push_op
);
	import mctg_pkg::*;

	logic [TEMP_W:0] cool_sum;

	assign item.ready = !q_stat.full;
	assign push       = item.valid && !q_stat.full;
	assign cool_sum   = {1'b0, item.temp_mc} + {1'b0, TEMP_HYST};

	always_comb begin
		push_op.core    = item.core_index;
		push_op.core_ok = (32'(item.core_index) < CORES);
		push_op.temp    = item.temp_mc;
		push_op.pstate  = item.pstate_value;
		push_op.last    = item.poll_last;

		case (item.action)
			ACT_SAMPLE:     push_op.kind = gov_enable ? OP_SAMPLE : OP_NONE;
			ACT_SET_PSTATE: push_op.kind = OP_SET_PSTATE;
			ACT_FAN:        push_op.kind = OP_FAN;
			default:        push_op.kind = OP_NONE;
		endcase

		if (item.temp_mc >= critical_limit) begin
			push_op.tclass = TC_CRITICAL;
		end else if (item.temp_mc >= passive_limit) begin
			push_op.tclass = TC_PASSIVE;
		end else if (cool_sum < {1'b0, passive_limit}) begin
			push_op.tclass = TC_COOL;
		end else begin
			push_op.tclass = TC_NONE;
		end

		if (item.fan_request > REQ_W'(DUTY_MAX)) begin
			push_op.duty = DUTY_MAX;
		end else if (item.fan_request < REQ_W'(DUTY_MIN)) begin
			push_op.duty = DUTY_MIN;
		end else begin
			push_op.duty = item.fan_request[DUTY_W-1:0];
		end
	end

endmodule

### hdl/mctg_queue.sv
// ----------------------------------------------------------------------------
// Multi-core thermal governor operation queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module mctg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mctg_pkg::op_t     push_op,
	input  logic              pop,
	output mctg_pkg::op_t     head_op,
	output mctg_pkg::q_stat_t q_stat
);
	import mctg_pkg::*;

	op_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_op      = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/mctg_back.sv
// ----------------------------------------------------------------------------
// Multi-core thermal governor back end
// Executes queued operations against the per-core tables and poll state,
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module mctg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mctg_pkg::op_t     head_op,
	input  mctg_pkg::q_stat_t q_stat,
	output logic              pop,
	mctg_out_if.source        result
);
	import mctg_pkg::*;

	logic [PST_W-1:0]  pstate_q   [CORES];
	logic              throttle_q [CORES];
	logic [CNT_W-1:0]  crit_cnt_q [CORES];
	logic [DUTY_W-1:0] fan_q;
	logic [TEMP_W-1:0] max_q;
	fan_req_t          freq_q;
	logic [POLL_W-1:0] polls_q;

	logic                  res_valid_q;
	logic [CORE_IDX_W-1:0] res_core_q;
	logic [PST_W-1:0]      res_pstate_q;
	logic [RATIO_W-1:0]    res_ratio_q;
	logic                  res_throttle_q;
	logic                  res_hit_q;
	logic [CNT_W-1:0]      res_cnt_q;
	logic [DUTY_W-1:0]     res_fan_q;
	logic [TEMP_W-1:0]     res_max_q;
	logic [POLL_W-1:0]     res_polls_q;
	logic                  res_done_q;

	logic [CORE_W-1:0] idx;
	logic [PST_W-1:0]  st_n;
	logic              thr_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [DUTY_W-1:0] fan_n;
	logic [TEMP_W-1:0] max_n;
	fan_req_t          freq_n;
	logic [POLL_W-1:0] polls_n;
	logic              hit;
	logic              done;

	assign idx = CORE_W'(head_op.core);
	assign pop = !q_stat.empty && (!res_valid_q || result.ready);

	always_comb begin
		st_n    = pstate_q[idx];
		thr_n   = throttle_q[idx];
		cnt_n   = crit_cnt_q[idx];
		fan_n   = fan_q;
		max_n   = max_q;
		freq_n  = freq_q;
		polls_n = polls_q;
		hit     = 1'b0;
		done    = 1'b0;

		case (head_op.kind)
			OP_SAMPLE: begin
				if (head_op.core_ok) begin
					if (head_op.temp > max_q) begin
						max_n = head_op.temp;
					end
					case (head_op.tclass)
						TC_CRITICAL: begin
							thr_n  = 1'b1;
							st_n   = PSTATE_THROTTLE;
							freq_n = FR_CRITICAL;
							hit    = 1'b1;
							if (cnt_n != '1) begin
								cnt_n = cnt_n + 1'b1;
							end
						end
						TC_PASSIVE: begin
							thr_n = 1'b1;
							if (st_n == PSTATE_TURBO) begin
								st_n = PSTATE_BASE;
							end
							if (freq_q == FR_NONE) begin
								freq_n = FR_PASSIVE;
							end
						end
						TC_COOL: begin
							if (thr_n) begin
								thr_n = 1'b0;
								st_n  = PSTATE_TURBO;
							end
						end
						default: begin
						end
					endcase
				end
				if (head_op.last) begin
					polls_n = polls_q + 1'b1;
					done    = 1'b1;
					if (max_n < TEMP_FAN_LOW) begin
						fan_n = DUTY_LOW;
					end else if (max_n < TEMP_FAN_MID) begin
						fan_n = DUTY_MID;
					end else if (freq_n == FR_CRITICAL) begin
						fan_n = DUTY_MAX;
					end else if (freq_n == FR_PASSIVE) begin
						fan_n = DUTY_PASSIVE;
					end
				end
			end
			OP_SET_PSTATE: begin
				if (head_op.core_ok) begin
					st_n = head_op.pstate;
				end
			end
			OP_FAN: begin
				fan_n = head_op.duty;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORES; i++) begin
				pstate_q[i]   <= PSTATE_TURBO;
				throttle_q[i] <= 1'b0;
				crit_cnt_q[i] <= '0;
			end
			fan_q       <= DUTY_RESET;
			max_q       <= '0;
			freq_q      <= FR_NONE;
			polls_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_op.core_ok) begin
					pstate_q[idx]   <= st_n;
					throttle_q[idx] <= thr_n;
					crit_cnt_q[idx] <= cnt_n;
				end
				fan_q   <= fan_n;
				polls_q <= polls_n;
				max_q   <= done ? '0 : max_n;
				freq_q  <= done ? FR_NONE : freq_n;
			end
			res_valid_q <= pop || (res_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_core_q     <= head_op.core;
			res_pstate_q   <= head_op.core_ok ? st_n : '0;
			res_ratio_q    <= head_op.core_ok ? ratio_of(st_n) : '0;
			res_throttle_q <= head_op.core_ok && thr_n;
			res_cnt_q      <= head_op.core_ok ? cnt_n : '0;
			res_hit_q      <= hit;
			res_fan_q      <= fan_n;
			res_max_q      <= max_n;
			res_polls_q    <= polls_n;
			res_done_q     <= done;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.out_core        = res_core_q;
	assign result.core_pstate     = res_pstate_q;
	assign result.perf_ratio      = res_ratio_q;
	assign result.core_throttling = res_throttle_q;
	assign result.critical_hit    = res_hit_q;
	assign result.critical_count  = res_cnt_q;
	assign result.fan_duty        = res_fan_q;
	assign result.max_temp_out    = res_max_q;
	assign result.poll_total      = res_polls_q;
	assign result.poll_done       = res_done_q;

endmodule

### hdl/multi_core_thermal_governor.sv
// ----------------------------------------------------------------------------
// Multi-core thermal governor
// Per-core throttling with hysteresis, poll-based fan duty selection and an
// APB register port for the enable bit and the two temperature limits.
//
// Input items arrive on the item channel, one result per item leaves on the
// result channel; both use valid/ready and a transfer happens when both are
// high. The front end classifies each item against the limits and writes it
// into a four-entry queue; the back end performs the per-core table update
// and loads the output register.
// Each item is registered first in the queue and then in the output register.
// Throughput is one item per cycle while the receiver takes the results,
// set by the per-core read-modify-write in the back end.
// When the receiver stalls, the result is held in the output register and
// the queue absorbs up to four further items before item.ready falls.
// Asynchronous reset clears all per-core state to turbo, not throttling,
// with zero critical counts, sets the fan duty to 35, clears the poll state
// and restores the register reset values. Registers are written at byte
// addresses 0, 4 and 8 and should be changed only while the block is idle.
// ----------------------------------------------------------------------------
module multi_core_thermal_governor (
	input  logic                            clk,
	input  logic                            arst_n,
	mctg_in_if.sink                         item,
	mctg_out_if.source                      result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mctg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mctg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mctg_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import mctg_pkg::*;

	logic              enable_q;
	logic [TEMP_W-1:0] passive_q;
	logic [TEMP_W-1:0] critical_q;
	logic              cfg_write;
	logic [1:0]        reg_sel;

	logic    push;
	logic    pop;
	op_t     push_op;
	op_t     head_op;
	q_stat_t q_stat;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			passive_q  <= PASSIVE_RESET;
			critical_q <= CRITICAL_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_ENABLE:   enable_q   <= pwdata[0];
				REG_PASSIVE:  passive_q  <= pwdata[TEMP_W-1:0];
				REG_CRITICAL: critical_q <= pwdata[TEMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ENABLE:   prdata = {{(APB_DATA_W-1){1'b0}}, enable_q};
			REG_PASSIVE:  prdata = {{(APB_DATA_W-TEMP_W){1'b0}}, passive_q};
			REG_CRITICAL: prdata = {{(APB_DATA_W-TEMP_W){1'b0}}, critical_q};
			default:      prdata = '0;
		endcase
	end

	mctg_front u_front (
		.item           (item),
		.gov_enable     (enable_q),
		.passive_limit  (passive_q),
		.critical_limit (critical_q),
		.q_stat         (q_stat),
		.push           (push),
		.push_op        (push_op)
	);

	mctg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.q_stat  (q_stat)
	);

	mctg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_op (head_op),
		.q_stat  (q_stat),
		.pop     (pop),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_fan_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.fan_duty >= DUTY_MIN) && (result.fan_duty <= DUTY_MAX))
		else $error("fan duty outside its clamp range");

	a_ratio_match: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.perf_ratio == ratio_of(result.core_pstate)) ||
		                 (result.perf_ratio == '0 && result.core_pstate == '0 &&
		                  !result.core_throttling))
		else $error("performance ratio does not match the reported state");

	a_critical_state: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.critical_hit |->
			result.core_pstate == PSTATE_THROTTLE && result.core_throttling &&
			result.critical_count != '0)
		else $error("critical sample without throttle state");
`endif

endmodule
